// ----- design/haversine_distance_unit_macros.svh -----
// Assertion macros for the haversine distance unit.
// Included by hav_queue, the module that checks its own logic; no other dependencies.
`ifndef HAVERSINE_DISTANCE_UNIT_MACROS_SVH
`define HAVERSINE_DISTANCE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HAV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("haversine assertion failed");
`define HAV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("haversine assertion failed");
`else
`define HAV_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HAV_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/hav_pkg.sv -----
// Shared constants, types and helpers of the haversine distance unit.
// No dependencies.
package hav_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 32;
   localparam int TABLE_LEN            = 48;
   localparam int QUEUE_DEPTH          = 4;
   localparam int ISQRT_BITS           = 31;

   localparam logic [23:0] RADIUS_RESET = 24'd6371000;

   localparam logic [63:0] PI_Q30       = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam logic [63:0] FULL_TURN    = 64'd3600000000;
   localparam logic [63:0] HALF_TURN    = 64'd1800000000;
   localparam logic [63:0] QUARTER_TURN = 64'd900000000;
   localparam logic [63:0] RECIP_TURN   = 64'd5124095576;
   localparam logic [63:0] RECIP_HALF   = 64'd10248191152;
   localparam logic [63:0] ONE_Q60      = 64'd1 << 60;

   localparam logic signed [35:0] ONE_Q30  = 36'sd1073741824;
   localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;

   localparam logic [29:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1,
      30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0,
      30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
   };

   typedef struct packed {
      logic [30:0] lat_diff;
      logic [30:0] lon_diff;
      logic [30:0] lat1_mag;
      logic        lat1_neg;
      logic [30:0] lat2_mag;
      logic        lat2_neg;
   } hav_item_type;

   function automatic logic [30:0] clamp_unit(input logic signed [35:0] v);
      logic [30:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > ONE_Q30) begin
         r = ONE_Q30[30:0];
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

endpackage

// ----- design/hav_front.sv -----
// Front end: takes requests, forms angle differences and folds latitudes.
// Depends on hav_pkg.
module hav_front import hav_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [30:0] lat_first,
   input  logic signed [31:0] lon_first,
   input  logic signed [30:0] lat_second,
   input  logic signed [31:0] lon_second,
   output logic               push,
   output hav_item_type       item
);

   localparam logic signed [34:0] TURN_S = $signed(FULL_TURN[34:0]);
   localparam logic signed [34:0] HALF_S = $signed(HALF_TURN[34:0]);

   logic               valid_ff;
   logic signed [32:0] dlat_ff;
   logic signed [32:0] dlon_ff;
   logic [30:0]        mag1_ff;
   logic [30:0]        mag2_ff;

   function automatic logic [30:0] reduce_turn(input logic signed [32:0] d);
      logic signed [34:0] r;
      r = {{2{d[32]}}, d};
      if (r < 0) r = r + TURN_S;
      if (r < 0) r = r + TURN_S;
      if (r >= TURN_S) r = r - TURN_S;
      if (r > HALF_S) r = TURN_S - r;
      return r[30:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dlat_ff <= {{2{lat_second[30]}}, lat_second} - {{2{lat_first[30]}}, lat_first};
         dlon_ff <= {lon_second[31], lon_second} - {lon_first[31], lon_first};
         mag1_ff <= lat_first[30] ? (~lat_first + 31'sd1) : lat_first;
         mag2_ff <= lat_second[30] ? (~lat_second + 31'sd1) : lat_second;
      end
   end

   always_comb begin
      push          = valid_ff;
      item.lat_diff = reduce_turn(dlat_ff);
      item.lon_diff = reduce_turn(dlon_ff);
      item.lat1_neg = ({1'b0, mag1_ff} > QUARTER_TURN[31:0]);
      item.lat2_neg = ({1'b0, mag2_ff} > QUARTER_TURN[31:0]);
      item.lat1_mag = item.lat1_neg ? (HALF_TURN[30:0] - mag1_ff) : mag1_ff;
      item.lat2_mag = item.lat2_neg ? (HALF_TURN[30:0] - mag2_ff) : mag2_ff;
   end

endmodule

// ----- design/hav_queue.sv -----
// Short queue between the front end and the arithmetic back end.
// Depends on hav_pkg and the assertion macros.
`include "haversine_distance_unit_macros.svh"
module hav_queue import hav_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_in,
   input  hav_item_type item_in,
   input  logic         pop_in,
   output logic         not_empty,
   output logic         almost_full,
   output hav_item_type item_out
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   hav_item_type    mem_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0]   wr_ff;
   logic [PW-1:0]   rd_ff;
   logic [PW:0]     count_ff;
   logic [PW:0]     count_in;

   always_comb begin
      count_in = count_ff;
      if (push_in && !pop_in) count_in = count_ff + 1'b1;
      if (!push_in && pop_in) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push_in) wr_ff <= wr_ff + 1'b1;
         if (pop_in) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in) mem_ff[wr_ff] <= item_in;
   end

   assign item_out    = mem_ff[rd_ff];
   assign not_empty   = (count_ff != '0);
   assign almost_full = (count_ff >= (PW+1)'(QUEUE_DEPTH - 1));

   `HAV_ASSERT_IMP(a_no_overflow, clock, reset, push_in, count_ff != (PW+1)'(QUEUE_DEPTH))
   `HAV_ASSERT_IMP(a_no_underflow, clock, reset, pop_in, count_ff != '0)
   `HAV_ASSERT_NXT(a_count_up, clock, reset, push_in && !pop_in, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- design/hav_rad_conv.sv -----
// Converts a 1e-7 degree angle to radians Q1.30, halved unless lat_mode,
// rounded; reciprocal multiply, remainder correction. Depends on hav_pkg.
module hav_rad_conv import hav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        lat_mode,
   input  logic        valid_in,
   input  logic        tag_in,
   input  logic [30:0] value,
   output logic        valid_out,
   output logic        tag_out,
   output logic [30:0] angle
);

   logic [3:0]  valid_ff;
   logic [3:0]  tag_ff;
   logic [62:0] n1_ff, n2_ff, n3_ff;
   logic [30:0] qe2_ff, qe3_ff;
   logic [62:0] p3_ff;
   logic [30:0] angle_ff;
   logic [63:0] div_c, recip_c, add_c;
   logic [64:0] qe_prod;
   logic [62:0] rem;
   logic [2:0]  qc;

   always_comb begin
      div_c   = lat_mode ? HALF_TURN : FULL_TURN;
      recip_c = lat_mode ? RECIP_HALF : RECIP_TURN;
      add_c   = lat_mode ? QUARTER_TURN : HALF_TURN;
      qe_prod = {34'd0, n1_ff[62:32]} * recip_c[33:0];
      rem     = n3_ff - p3_ff;
      qc      = {2'b0, rem >= div_c[62:0]} + {2'b0, rem >= (div_c[62:0] << 1)}
              + {2'b0, rem >= 63'(div_c * 3)} + {2'b0, rem >= (div_c[62:0] << 2)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= {tag_ff[2:0], tag_in};
      n1_ff    <= 63'({32'd0, value} * PI_Q30[31:0]) + add_c[62:0];
      n2_ff    <= n1_ff;
      qe2_ff   <= qe_prod[62:32];
      n3_ff    <= n2_ff;
      qe3_ff   <= qe2_ff;
      p3_ff    <= 63'({32'd0, qe2_ff} * div_c[31:0]);
      angle_ff <= qe3_ff + {28'd0, qc};
   end

   assign valid_out = valid_ff[3];
   assign tag_out   = tag_ff[3];
   assign angle     = angle_ff;

endmodule

// ----- design/hav_cordic_rot.sv -----
// Pipelined rotation CORDIC, one stage per iteration: cos and sin Q1.30.
// Depends on hav_pkg.
module hav_cordic_rot import hav_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic        tag_in,
   input  logic [30:0] angle,
   output logic        valid_out,
   output logic        tag_out,
   output logic [30:0] cos_q,
   output logic [30:0] sin_q
);

   logic signed [35:0] x_ff [0:STEPS];
   logic signed [35:0] y_ff [0:STEPS];
   logic signed [33:0] z_ff [0:STEPS];
   logic [STEPS:0]     vld_ff;
   logic [STEPS:0]     tag_ff;
   logic               vout_ff;
   logic               tout_ff;
   logic [30:0]        cos_ff;
   logic [30:0]        sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         vout_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[STEPS-1:0], valid_in};
         vout_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= {tag_ff[STEPS-1:0], tag_in};
      tout_ff <= tag_ff[STEPS];
      x_ff[0] <= GAIN_Q30;
      y_ff[0] <= '0;
      z_ff[0] <= {3'b0, angle};
      cos_ff  <= clamp_unit(x_ff[STEPS]);
      sin_ff  <= clamp_unit(y_ff[STEPS]);
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [35:0] xs, ys;
      logic signed [33:0] at;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = {4'b0, ATAN_TABLE[i]};
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - at;
         end else begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + at;
         end
      end
   end

   assign valid_out = vout_ff;
   assign tag_out   = tout_ff;
   assign cos_q     = cos_ff;
   assign sin_q     = sin_ff;

endmodule

// ----- design/hav_isqrt.sv -----
// Pipelined floor square root, one result bit per stage: Q1.60 in, Q1.30 out.
// Depends on hav_pkg.
module hav_isqrt import hav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic [60:0] value,
   output logic        valid_out,
   output logic [30:0] root
);

   logic [60:0]         rem_ff  [0:ISQRT_BITS];
   logic [30:0]         root_ff [0:ISQRT_BITS];
   logic [ISQRT_BITS:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ISQRT_BITS-1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= value;
      root_ff[0] <= '0;
   end

   for (genvar k = 0; k < ISQRT_BITS; k++) begin : g_bit
      localparam int B = ISQRT_BITS - 1 - k;
      logic [62:0] trial;
      assign trial = ({32'd0, root_ff[k]} << (B + 1)) + (63'd1 << (2 * B));
      always_ff @(posedge clock) begin
         if ({2'b0, rem_ff[k]} >= trial) begin
            rem_ff[k+1]  <= rem_ff[k] - trial[60:0];
            root_ff[k+1] <= root_ff[k] | (31'd1 << B);
         end else begin
            rem_ff[k+1]  <= rem_ff[k];
            root_ff[k+1] <= root_ff[k];
         end
      end
   end

   assign valid_out = vld_ff[ISQRT_BITS];
   assign root      = root_ff[ISQRT_BITS];

endmodule

// ----- design/hav_cordic_vec.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) in radians Q1.30, clamped to [0, pi/2].
// Depends on hav_pkg.
module hav_cordic_vec import hav_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic [30:0] y_in,
   input  logic [30:0] x_in,
   output logic        valid_out,
   output logic [30:0] angle
);

   localparam logic signed [33:0] HALF_PI_S = $signed(HALF_PI_Q30[33:0]);

   logic signed [35:0] x_ff [0:STEPS];
   logic signed [35:0] y_ff [0:STEPS];
   logic signed [33:0] z_ff [0:STEPS];
   logic [STEPS:0]     vld_ff;
   logic               vout_ff;
   logic [30:0]        angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         vout_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[STEPS-1:0], valid_in};
         vout_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= {5'b0, x_in};
      y_ff[0] <= {5'b0, y_in};
      z_ff[0] <= '0;
      if (z_ff[STEPS] < 0) begin
         angle_ff <= '0;
      end else if (z_ff[STEPS] > HALF_PI_S) begin
         angle_ff <= HALF_PI_Q30[30:0];
      end else begin
         angle_ff <= z_ff[STEPS][30:0];
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [35:0] xs, ys;
      logic signed [33:0] at;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = {4'b0, ATAN_TABLE[i]};
      always_ff @(posedge clock) begin
         if (y_ff[i] > 0) begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + at;
         end else begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - at;
         end
      end
   end

   assign valid_out = vout_ff;
   assign angle     = angle_ff;

endmodule

// ----- design/hav_back.sv -----
// Back end: radian conversion, CORDIC sines and cosines, the haversine term,
// square roots, atan2 and scaling to centimeters. Depends on hav_pkg and the units.
module hav_back import hav_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   input  hav_item_type item,
   input  logic [23:0]  radius,
   output logic         rsp_strobe,
   output logic [31:0]  rsp_distance_cm
);

   localparam logic [61:0] HALF_Q = 62'd1 << 29;

   logic        rv_lat;
   logic        rt1, rt2;
   logic [30:0] ang_lat, ang_lon, ang_c1, ang_c2;
   logic        cv;
   logic        neg1, neg2;
   logic [30:0] s1, s2, m1, m2;

   hav_rad_conv u_rad_lat (.clock, .reset, .lat_mode(1'b0), .valid_in, .tag_in(1'b0),
      .value(item.lat_diff), .valid_out(rv_lat), .tag_out(), .angle(ang_lat));
   hav_rad_conv u_rad_lon (.clock, .reset, .lat_mode(1'b0), .valid_in, .tag_in(1'b0),
      .value(item.lon_diff), .valid_out(), .tag_out(), .angle(ang_lon));
   hav_rad_conv u_rad_c1 (.clock, .reset, .lat_mode(1'b1), .valid_in, .tag_in(item.lat1_neg),
      .value(item.lat1_mag), .valid_out(), .tag_out(rt1), .angle(ang_c1));
   hav_rad_conv u_rad_c2 (.clock, .reset, .lat_mode(1'b1), .valid_in, .tag_in(item.lat2_neg),
      .value(item.lat2_mag), .valid_out(), .tag_out(rt2), .angle(ang_c2));

   hav_cordic_rot #(.STEPS(STEPS)) u_rot_lat (.clock, .reset, .valid_in(rv_lat),
      .tag_in(1'b0), .angle(ang_lat), .valid_out(cv), .tag_out(),
      .cos_q(), .sin_q(s1));
   hav_cordic_rot #(.STEPS(STEPS)) u_rot_lon (.clock, .reset, .valid_in(rv_lat),
      .tag_in(1'b0), .angle(ang_lon), .valid_out(), .tag_out(),
      .cos_q(), .sin_q(s2));
   hav_cordic_rot #(.STEPS(STEPS)) u_rot_c1 (.clock, .reset, .valid_in(rv_lat),
      .tag_in(rt1), .angle(ang_c1), .valid_out(), .tag_out(neg1),
      .cos_q(m1), .sin_q());
   hav_cordic_rot #(.STEPS(STEPS)) u_rot_c2 (.clock, .reset, .valid_in(rv_lat),
      .tag_in(rt2), .angle(ang_c2), .valid_out(), .tag_out(neg2),
      .cos_q(m2), .sin_q());

   logic [4:0]  mv_ff;
   logic [61:0] t1_1_ff, t1_2_ff, t1_3_ff, mm_ff, u_ff, t2_ff;
   logic [30:0] s2_1_ff, s2_2_ff;
   logic        neg_1_ff, neg_2_ff, neg_3_ff;
   logic [60:0] a_ff, a5_ff, b5_ff;
   logic [61:0] mm_r, u_r, a_sum;
   logic [60:0] a_in;

   always_comb begin
      mm_r = mm_ff + HALF_Q;
      u_r  = u_ff + HALF_Q;
      if (neg_3_ff) begin
         a_sum = (t1_3_ff >= t2_ff) ? (t1_3_ff - t2_ff) : '0;
      end else begin
         a_sum = t1_3_ff + t2_ff;
      end
      a_in = (a_sum > ONE_Q60[61:0]) ? ONE_Q60[60:0] : a_sum[60:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= '0;
      end else begin
         mv_ff <= {mv_ff[3:0], cv};
      end
   end

   always_ff @(posedge clock) begin
      t1_1_ff  <= {31'd0, s1} * {31'd0, s1};
      mm_ff    <= {31'd0, m1} * {31'd0, m2};
      s2_1_ff  <= s2;
      neg_1_ff <= neg1 ^ neg2;
      u_ff     <= {31'd0, mm_r[60:30]} * {31'd0, s2_1_ff};
      t1_2_ff  <= t1_1_ff;
      s2_2_ff  <= s2_1_ff;
      neg_2_ff <= neg_1_ff;
      t2_ff    <= {31'd0, u_r[60:30]} * {31'd0, s2_2_ff};
      t1_3_ff  <= t1_2_ff;
      neg_3_ff <= neg_2_ff;
      a_ff     <= a_in;
      a5_ff    <= a_ff;
      b5_ff    <= ONE_Q60[60:0] - a_ff;
   end

   logic        sv, av;
   logic [30:0] sa, sb, ang;

   hav_isqrt u_sqrt_a (.clock, .reset, .valid_in(mv_ff[4]), .value(a5_ff),
      .valid_out(sv), .root(sa));
   hav_isqrt u_sqrt_b (.clock, .reset, .valid_in(mv_ff[4]), .value(b5_ff),
      .valid_out(), .root(sb));

   hav_cordic_vec #(.STEPS(STEPS)) u_atan (.clock, .reset, .valid_in(sv), .y_in(sa),
      .x_in(sb), .valid_out(av), .angle(ang));

   logic [1:0]  ov_ff;
   logic [55:0] q_ff;
   logic [31:0] dist_ff;
   logic [32:0] whole;
   logic [36:0] frac;
   logic [33:0] dist_sum;

   always_comb begin
      whole    = 33'(q_ff[55:30]) * 33'd100;
      frac     = 37'(q_ff[29:0]) * 37'd100 + 37'(HALF_Q);
      dist_sum = {1'b0, whole} + {27'd0, frac[36:30]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= '0;
      end else begin
         ov_ff <= {ov_ff[0], av};
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= {32'd0, radius} * {24'd0, ang, 1'b0};
      dist_ff <= (dist_sum > 34'hFFFFFFFF) ? 32'hFFFFFFFF : dist_sum[31:0];
   end

   assign rsp_strobe      = ov_ff[1];
   assign rsp_distance_cm = dist_ff;

endmodule

// ----- design/haversine_distance_unit.sv -----
// Top level of the haversine great-circle distance unit.
// Depends on hav_pkg, hav_front, hav_queue and hav_back.
//
//  channel   ports                               handshake
//  request   req_lat/lon_first/second            start high, busy low
//  result    rsp_distance_cm                     rsp_strobe, one cycle, no stall
//  config    csr_wdata (earth radius, meters)    csr_valid and csr_ready
//
// One request per cycle sustained; busy rises only if the queue backs up.
// STEPS = min(CORDIC_STEPS, 48) sets the depth of the rotation and vectoring CORDIC
// pipelines, which lie in series with the square root.
// Synchronous reset clears control and sets the radius to 6371000 m.
// Results cannot be held off: each is presented for exactly one cycle.
module haversine_distance_unit import hav_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_lat_first,
   input  logic signed [31:0] req_lon_first,
   input  logic signed [30:0] req_lat_second,
   input  logic signed [31:0] req_lon_second,
   output logic               rsp_strobe,
   output logic [31:0]        rsp_distance_cm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_wdata
);

   localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   logic [23:0]  radius_ff;
   logic         accept, push, not_empty;
   hav_item_type item_front, item_back;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_wdata;
      end
   end

   hav_front u_front (
      .clock, .reset, .accept,
      .lat_first(req_lat_first), .lon_first(req_lon_first),
      .lat_second(req_lat_second), .lon_second(req_lon_second),
      .push, .item(item_front)
   );

   hav_queue u_queue (
      .clock, .reset, .push_in(push), .item_in(item_front), .pop_in(not_empty),
      .not_empty, .almost_full(busy), .item_out(item_back)
   );

   hav_back #(.STEPS(STEPS)) u_back (
      .clock, .reset, .valid_in(not_empty), .item(item_back), .radius(radius_ff),
      .rsp_strobe, .rsp_distance_cm
   );

endmodule

// ----- verif/haversine_distance_unit_test.sv -----
// Testbench for haversine_distance_unit: a table of directed requests, then random ones,
// with each distance checked against a fixed-point model kept here or a typed-in zero.
// Depends on hav_pkg and the haversine_distance_unit RTL.
`timescale 1ns / 1ps

module haversine_distance_unit_test import hav_pkg::*;;

   localparam int      STEPS    = 32;
   localparam int      LATENCY  = 2 * STEPS + 49;
   localparam longint  TURN     = 64'sd3600000000;
   localparam longint  HALF     = 64'sd1800000000;
   localparam longint  QUARTER  = 64'sd900000000;
   localparam longint  PI       = 64'sd3373259426;
   localparam longint  UNIT     = 64'sd1073741824;
   localparam longint  GAIN     = 64'sd652032874;
   localparam longint  ONE60    = 64'sd1 << 60;
   localparam longint  RND      = 64'sd1 << 29;

   typedef struct {
      logic signed [30:0] lat1;
      logic signed [31:0] lon1;
      logic signed [30:0] lat2;
      logic signed [31:0] lon2;
   } point_pair_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [30:0] req_lat_first;
   logic signed [31:0] req_lon_first;
   logic signed [30:0] req_lat_second;
   logic signed [31:0] req_lon_second;
   logic               rsp_strobe;
   logic [31:0]        rsp_distance_cm;
   logic               csr_valid;
   logic               csr_ready;
   logic [23:0]        csr_wdata;

   logic [31:0]    pending_dist[$];
   logic [23:0]    radius_m;
   int             mismatches;
   point_pair_type pair_table[$];

   haversine_distance_unit #(.CORDIC_STEPS(STEPS)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("** haversine_distance_unit: FAILED **");
      $finish;
   end

   function automatic void cordic_rotate(input longint ang, output longint cs,
                                         output longint sn);
      longint x, y, z, nx, ny;
      x = GAIN;
      y = 0;
      z = ang;
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_TABLE[i]);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_TABLE[i]);
         end
         x = nx;
         y = ny;
      end
      cs = x;
      sn = y;
   endfunction

   function automatic longint cordic_angle(input longint yi, input longint xi);
      longint x, y, z, nx, ny;
      x = xi;
      y = yi;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_TABLE[i]);
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_TABLE[i]);
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > (PI >>> 1)) z = PI >>> 1;
      return z;
   endfunction

   function automatic longint unit_clamp(input longint v, input longint lo);
      return v < lo ? lo : (v > UNIT ? UNIT : v);
   endfunction

   function automatic longint half_angle_sine(input longint d);
      longint r, cs, sn;
      r = d % TURN;
      if (r < 0) r += TURN;
      if (r > HALF) r = TURN - r;
      cordic_rotate((r * PI + HALF) / TURN, cs, sn);
      return unit_clamp(sn, 0);
   endfunction

   function automatic longint latitude_cosine(input longint lat);
      longint m, cs, sn;
      bit     flip;
      m = lat < 0 ? -lat : lat;
      flip = 1'b0;
      if (m > QUARTER) begin
         m = HALF - m;
         flip = 1'b1;
      end
      cordic_rotate((m * PI + QUARTER) / HALF, cs, sn);
      cs = unit_clamp(cs, 0);
      return flip ? -cs : cs;
   endfunction

   function automatic longint floor_root(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic logic [31:0] great_circle_cm(input point_pair_type p,
                                                   input logic [23:0] r);
      longint s1, s2, c1, c2, m1, m2, t1, t2, ccq, a, c;
      longint unsigned q, dist_cm;
      s1 = half_angle_sine(longint'(p.lat2) - longint'(p.lat1));
      s2 = half_angle_sine(longint'(p.lon2) - longint'(p.lon1));
      c1 = latitude_cosine(longint'(p.lat1));
      c2 = latitude_cosine(longint'(p.lat2));
      m1 = c1 < 0 ? -c1 : c1;
      m2 = c2 < 0 ? -c2 : c2;
      t1 = s1 * s1;
      ccq = (m1 * m2 + RND) >>> 30;
      t2 = ((ccq * s2 + RND) >>> 30) * s2;
      if ((c1 < 0) != (c2 < 0)) a = t1 >= t2 ? t1 - t2 : 0;
      else a = t1 + t2;
      if (a > ONE60) a = ONE60;
      c = 2 * cordic_angle(floor_root(a), floor_root(ONE60 - a));
      q = longint'(r) * c;
      dist_cm = (q >> 30) * 100 + (((q & ((64'd1 << 30) - 1)) * 100 + RND) >> 30);
      if (dist_cm > 64'hFFFF_FFFF) dist_cm = 64'hFFFF_FFFF;
      return dist_cm[31:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_distance_cm);
         end else begin
            logic [31:0] want;
            want = pending_dist.pop_front();
            if (want !== rsp_distance_cm) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("distance_cm mismatch: expected %0d, got %0d", want,
                           rsp_distance_cm);
            end
         end
      end
   end

   task automatic gap_cycles();
      int n;
      n = ($urandom_range(9) < 6) ? 0 :
          ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // typed_zero: expectation read off directly (zero radius gives zero distance)
   task automatic send_pair(input point_pair_type p, input bit typed_zero);
      req_lat_first  <= p.lat1;
      req_lon_first  <= p.lon1;
      req_lat_second <= p.lat2;
      req_lon_second <= p.lon2;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      pending_dist.push_back(typed_zero ? 32'd0 : great_circle_cm(p, radius_m));
      gap_cycles();
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_radius(input logic [23:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      radius_m = v;
   endtask

   function automatic point_pair_type random_pair();
      point_pair_type p;
      int             k;
      k = $urandom_range(9);
      p.lat1 = (k == 0) ? 31'($urandom()) :
               31'(int'($urandom_range(1800000000)) - 900000000);
      p.lon1 = (k == 1) ? $urandom() : int'($urandom_range(3600000000)) - 1800000000;
      if (k >= 7) begin
         // nearby second point, short distances
         p.lat2 = 31'(p.lat1 + int'($urandom_range(20000)) - 10000);
         p.lon2 = p.lon1 + int'($urandom_range(20000)) - 10000;
      end else begin
         p.lat2 = (k == 2) ? 31'($urandom()) :
                  31'(int'($urandom_range(1800000000)) - 900000000);
         p.lon2 = (k == 3) ? $urandom() : int'($urandom_range(3600000000)) - 1800000000;
      end
      return p;
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) send_pair(random_pair(), 1'b0);
   endtask

   initial begin
      logic [23:0] radii[4];
      mismatches = 0;
      radius_m = RADIUS_RESET;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      req_lat_first = '0;
      req_lon_first = '0;
      req_lat_second = '0;
      req_lon_second = '0;
      reset = 1'b1;
      pair_table = '{
         '{31'sd0, 32'sd0, 31'sd0, 32'sd0},
         '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0},
         '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000},
         '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000},
         '{31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000},
         '{31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000},
         '{-31'sd900000000, 32'sd0, -31'sd900000000, 32'sd1234567},
         '{31'sd0, 32'sd0, 31'sd1, 32'sd1},
         '{31'sd123456789, 32'sd987654321, 31'sd123456789, 32'sd987654321},
         '{31'sh3FFFFFFF, 32'sh7FFFFFFF, -31'sh40000000, -32'sh80000000},
         '{-31'sh40000000, -32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF},
         '{31'sd1000000000, 32'sd0, 31'sd0, 32'sd0},
         '{31'sd1000000000, 32'sd0, -31'sd1000000000, 32'sd1800000000},
         '{31'sd0, 32'sd0, 31'sd0, 32'sd900000000},
         '{31'sd515000000, -32'sd1000000, 31'sd408000000, -32'sd740000000},
         '{31'sd10, -32'sd10, -31'sd10, 32'sd10}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pair_table[i]) send_pair(pair_table[i], 1'b0);
      random_phase(330);

      write_radius(24'd0);
      foreach (pair_table[i]) send_pair(pair_table[i], 1'b1);
      random_phase(40);

      radii = '{24'd1, 24'd16777215, 24'($urandom_range(16777215, 1)), 24'd6371000};
      foreach (radii[r]) begin
         write_radius(radii[r]);
         foreach (pair_table[i]) send_pair(pair_table[i], 1'b0);
         random_phase(300);
      end

      drain();
      if (mismatches == 0) begin
         $display("** haversine_distance_unit: PASSED **");
      end else begin
         $display("** haversine_distance_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/hav_pkg.sv
design/hav_front.sv
design/hav_queue.sv
design/hav_rad_conv.sv
design/hav_cordic_rot.sv
design/hav_isqrt.sv
design/hav_cordic_vec.sv
design/hav_back.sv
design/haversine_distance_unit.sv
verif/haversine_distance_unit_test.sv
